/* rtl/tsch_slot_sequencer_core_defines.svh */
// Assertion macros shared by the sequencer checker.
// Depends on nothing; the using module supplies aclk and aresetn.
`ifndef TSCH_SLOT_SEQUENCER_CORE_DEFINES_SVH
`define TSCH_SLOT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tsch_ss_pkg.sv */
// Shared types and codes of the TSCH slot sequencer.
// Used by the sequencer state logic, the remainder pipeline and the top level.
package tsch_ss_pkg;

    localparam int unsigned FRAME_SLOTS_DEF = 16;
    localparam int unsigned SLOT_BITS_DEF   = 40;

    // events
    localparam logic [1:0] EV_TICK  = 2'd0;
    localparam logic [1:0] EV_TIMER = 2'd1;
    localparam logic [1:0] EV_START = 2'd2;
    localparam logic [1:0] EV_END   = 2'd3;

    // schedule cells
    localparam logic [2:0] CELL_OFF = 3'd0;
    localparam logic [2:0] CELL_ADV = 3'd1;
    localparam logic [2:0] CELL_TX  = 3'd2;
    localparam logic [2:0] CELL_RX  = 3'd3;

    // slot phases
    localparam logic [4:0] PH_SLEEP      = 5'd0;
    localparam logic [4:0] PH_SYNC       = 5'd1;
    localparam logic [4:0] PH_TXD_OFS    = 5'd2;
    localparam logic [4:0] PH_TXD_PREP   = 5'd3;
    localparam logic [4:0] PH_TXD_READY  = 5'd4;
    localparam logic [4:0] PH_TXD_DELAY  = 5'd5;
    localparam logic [4:0] PH_TXD        = 5'd6;
    localparam logic [4:0] PH_RXA_OFS    = 5'd7;
    localparam logic [4:0] PH_RXA_PREP   = 5'd8;
    localparam logic [4:0] PH_RXA_READY  = 5'd9;
    localparam logic [4:0] PH_RXA_LISTEN = 5'd10;
    localparam logic [4:0] PH_RXA        = 5'd11;
    localparam logic [4:0] PH_RXD_OFS    = 5'd12;
    localparam logic [4:0] PH_RXD_PREP   = 5'd13;
    localparam logic [4:0] PH_RXD_READY  = 5'd14;
    localparam logic [4:0] PH_RXD_LISTEN = 5'd15;
    localparam logic [4:0] PH_RXD        = 5'd16;
    localparam logic [4:0] PH_TXA_OFS    = 5'd17;
    localparam logic [4:0] PH_TXA_PREP   = 5'd18;
    localparam logic [4:0] PH_TXA_READY  = 5'd19;
    localparam logic [4:0] PH_TXA_DELAY  = 5'd20;
    localparam logic [4:0] PH_TXA        = 5'd21;

    // radio commands
    localparam logic [2:0] RADIO_NONE   = 3'd0;
    localparam logic [2:0] RADIO_OFF    = 3'd1;
    localparam logic [2:0] RADIO_SYNC   = 3'd2;
    localparam logic [2:0] RADIO_TX_EN  = 3'd3;
    localparam logic [2:0] RADIO_TX_NOW = 3'd4;
    localparam logic [2:0] RADIO_RX_EN  = 3'd5;
    localparam logic [2:0] RADIO_RX_NOW = 3'd6;

    // timer commands
    localparam logic [1:0] TMR_NONE       = 2'd0;
    localparam logic [1:0] TMR_CANCEL     = 2'd1;
    localparam logic [1:0] TMR_ARM        = 2'd2;
    localparam logic [1:0] TMR_CANCEL_ARM = 2'd3;

    // timer durations
    localparam logic [3:0] TSEL_NONE = 4'd0;
    localparam logic [3:0] TSEL_TT1  = 4'd0;
    localparam logic [3:0] TSEL_TT2  = 4'd1;
    localparam logic [3:0] TSEL_TT3  = 4'd2;
    localparam logic [3:0] TSEL_TT4  = 4'd3;
    localparam logic [3:0] TSEL_TT5  = 4'd4;
    localparam logic [3:0] TSEL_TT6  = 4'd5;
    localparam logic [3:0] TSEL_TT7  = 4'd6;
    localparam logic [3:0] TSEL_TT8  = 4'd7;
    localparam logic [3:0] TSEL_RT1  = 4'd8;
    localparam logic [3:0] TSEL_RT2  = 4'd9;
    localparam logic [3:0] TSEL_RT3  = 4'd10;
    localparam logic [3:0] TSEL_RT4  = 4'd11;
    localparam logic [3:0] TSEL_RT5  = 4'd12;
    localparam logic [3:0] TSEL_RT6  = 4'd13;
    localparam logic [3:0] TSEL_RT7  = 4'd14;
    localparam logic [3:0] TSEL_RT8  = 4'd15;

    // send reports
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_OK   = 2'd1;
    localparam logic [1:0] SEND_FAIL = 2'd2;

    // error codes
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_TIMER_PHASE   = 4'd1;
    localparam logic [3:0] ERR_START_PHASE   = 4'd2;
    localparam logic [3:0] ERR_END_PHASE     = 4'd3;
    localparam logic [3:0] ERR_TICK_BUSY     = 4'd4;
    localparam logic [3:0] ERR_BAD_CELL      = 4'd5;
    localparam logic [3:0] ERR_NO_BUFFER     = 4'd6;
    localparam logic [3:0] ERR_TXD_PREP      = 4'd7;
    localparam logic [3:0] ERR_TXD_WDOG      = 4'd8;
    localparam logic [3:0] ERR_DATA_DUR      = 4'd9;
    localparam logic [3:0] ERR_RXA_PREP      = 4'd10;
    localparam logic [3:0] ERR_RXD_PREP      = 4'd11;
    localparam logic [3:0] ERR_TXA_PREP      = 4'd12;
    localparam logic [3:0] ERR_TXA_WDOG      = 4'd13;
    localparam logic [3:0] ERR_ACK_DUR       = 4'd14;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] captured_time;
        logic [2:0]  cell_type;
        logic        packet_ready;
        logic        packet_broadcast;
        logic [3:0]  packet_retries;
        logic        buffer_free;
        logic        frame_is_beacon;
    } ev_t;

    typedef struct packed {
        logic [4:0]  fsm_code;
        logic [2:0]  radio_cmd;
        logic [1:0]  timer_cmd;
        logic [3:0]  timer_select;
        logic [1:0]  send_status;
        logic        deliver_frame;
        logic [3:0]  retries_after;
        logic [3:0]  error_code;
        logic [15:0] last_capture;
    } res_t;

endpackage

/* rtl/tsch_ss_fsm.sv */
// Slot state machine: state registers and the single-pass event update.
// Depends on tsch_ss_pkg.
module tsch_ss_fsm #(
    parameter int unsigned SLOT_BITS = tsch_ss_pkg::SLOT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  step,
    input  tsch_ss_pkg::ev_t      ev,
    input  logic [SLOT_BITS-1:0]  beacon_slot,
    output tsch_ss_pkg::res_t     res,
    output logic [SLOT_BITS-1:0]  slot_out
);

    logic [4:0]           phase_reg,    phase_next;
    logic [SLOT_BITS-1:0] slot_reg,     slot_next;
    logic                 synced_reg,   synced_next;
    logic [15:0]          capture_reg,  capture_next;
    logic                 hold_tx_reg,  hold_tx_next;
    logic [3:0]           retries_reg,  retries_next;
    logic                 bcast_reg,    bcast_next;
    logic                 hold_rx_reg,  hold_rx_next;

    logic [2:0] radio;
    logic [1:0] tcmd;
    logic [3:0] tsel;
    logic [1:0] send;
    logic       deliver;
    logic [3:0] err;
    logic       end_slot;

    always_comb begin
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        synced_next  = synced_reg;
        capture_next = capture_reg;
        hold_tx_next = hold_tx_reg;
        retries_next = retries_reg;
        bcast_next   = bcast_reg;
        hold_rx_next = hold_rx_reg;
        radio    = tsch_ss_pkg::RADIO_NONE;
        tcmd     = tsch_ss_pkg::TMR_NONE;
        tsel     = tsch_ss_pkg::TSEL_NONE;
        send     = tsch_ss_pkg::SEND_NONE;
        deliver  = 1'b0;
        err      = tsch_ss_pkg::ERR_NONE;
        end_slot = 1'b0;

        case (ev.command)
            tsch_ss_pkg::EV_TICK: begin
                if (!synced_reg) begin
                    if (phase_reg != tsch_ss_pkg::PH_SYNC) begin
                        phase_next = tsch_ss_pkg::PH_SYNC;
                        radio      = tsch_ss_pkg::RADIO_SYNC;
                    end
                end else begin
                    slot_next = slot_reg + SLOT_BITS'(1);
                    if (phase_reg != tsch_ss_pkg::PH_SLEEP) begin
                        err      = tsch_ss_pkg::ERR_TICK_BUSY;
                        end_slot = 1'b1;
                    end else begin
                        case (ev.cell_type)
                            tsch_ss_pkg::CELL_OFF: begin
                                end_slot = 1'b1;
                            end
                            tsch_ss_pkg::CELL_ADV, tsch_ss_pkg::CELL_TX: begin
                                if (ev.packet_ready) begin
                                    hold_tx_next = 1'b1;
                                    retries_next = ev.packet_retries;
                                    bcast_next   = ev.packet_broadcast;
                                    phase_next   = tsch_ss_pkg::PH_TXD_OFS;
                                    tcmd         = tsch_ss_pkg::TMR_ARM;
                                    tsel         = tsch_ss_pkg::TSEL_TT1;
                                end else if (ev.cell_type == tsch_ss_pkg::CELL_ADV) begin
                                    phase_next = tsch_ss_pkg::PH_RXD_OFS;
                                    tcmd       = tsch_ss_pkg::TMR_ARM;
                                    tsel       = tsch_ss_pkg::TSEL_RT1;
                                end else begin
                                    end_slot = 1'b1;
                                end
                            end
                            tsch_ss_pkg::CELL_RX: begin
                                phase_next = tsch_ss_pkg::PH_RXD_OFS;
                                tcmd       = tsch_ss_pkg::TMR_ARM;
                                tsel       = tsch_ss_pkg::TSEL_RT1;
                            end
                            default: begin
                                err      = tsch_ss_pkg::ERR_BAD_CELL;
                                end_slot = 1'b1;
                            end
                        endcase
                    end
                end
            end
            tsch_ss_pkg::EV_TIMER: begin
                case (phase_reg)
                    tsch_ss_pkg::PH_TXD_OFS: begin
                        radio = tsch_ss_pkg::RADIO_TX_EN;
                        tcmd  = tsch_ss_pkg::TMR_ARM;
                        tsel  = tsch_ss_pkg::TSEL_TT2;
                        phase_next = tsch_ss_pkg::PH_TXD_READY;
                    end
                    tsch_ss_pkg::PH_TXD_PREP: begin
                        err = tsch_ss_pkg::ERR_TXD_PREP; end_slot = 1'b1;
                    end
                    tsch_ss_pkg::PH_TXD_READY: begin
                        radio = tsch_ss_pkg::RADIO_TX_NOW;
                        tcmd  = tsch_ss_pkg::TMR_ARM;
                        tsel  = tsch_ss_pkg::TSEL_TT3;
                        phase_next = tsch_ss_pkg::PH_TXD_DELAY;
                    end
                    tsch_ss_pkg::PH_TXD_DELAY: begin
                        err = tsch_ss_pkg::ERR_TXD_WDOG; end_slot = 1'b1;
                    end
                    tsch_ss_pkg::PH_TXD: begin
                        err = tsch_ss_pkg::ERR_DATA_DUR; end_slot = 1'b1;
                    end
                    tsch_ss_pkg::PH_RXA_OFS: begin
                        radio = tsch_ss_pkg::RADIO_RX_EN;
                        tcmd  = tsch_ss_pkg::TMR_ARM;
                        tsel  = tsch_ss_pkg::TSEL_TT6;
                        phase_next = tsch_ss_pkg::PH_RXA_READY;
                    end
                    tsch_ss_pkg::PH_RXA_PREP: begin
                        err = tsch_ss_pkg::ERR_RXA_PREP; end_slot = 1'b1;
                    end
                    tsch_ss_pkg::PH_RXA_READY: begin
                        radio = tsch_ss_pkg::RADIO_RX_NOW;
                        tcmd  = tsch_ss_pkg::TMR_ARM;
                        tsel  = tsch_ss_pkg::TSEL_TT7;
                        phase_next = tsch_ss_pkg::PH_RXA_LISTEN;
                    end
                    tsch_ss_pkg::PH_RXA_LISTEN, tsch_ss_pkg::PH_RXA,
                    tsch_ss_pkg::PH_RXD_LISTEN: begin
                        end_slot = 1'b1;
                    end
                    tsch_ss_pkg::PH_RXD_OFS: begin
                        radio = tsch_ss_pkg::RADIO_RX_EN;
                        tcmd  = tsch_ss_pkg::TMR_ARM;
                        tsel  = tsch_ss_pkg::TSEL_RT2;
                        phase_next = tsch_ss_pkg::PH_RXD_READY;
                    end
                    tsch_ss_pkg::PH_RXD_PREP: begin
                        err = tsch_ss_pkg::ERR_RXD_PREP; end_slot = 1'b1;
                    end
                    tsch_ss_pkg::PH_RXD_READY: begin
                        radio = tsch_ss_pkg::RADIO_RX_NOW;
                        tcmd  = tsch_ss_pkg::TMR_ARM;
                        tsel  = tsch_ss_pkg::TSEL_RT3;
                        phase_next = tsch_ss_pkg::PH_RXD_LISTEN;
                    end
                    tsch_ss_pkg::PH_RXD: begin
                        err = tsch_ss_pkg::ERR_DATA_DUR; end_slot = 1'b1;
                    end
                    tsch_ss_pkg::PH_TXA_OFS: begin
                        if (!ev.buffer_free) begin
                            err = tsch_ss_pkg::ERR_NO_BUFFER; end_slot = 1'b1;
                        end else begin
                            radio = tsch_ss_pkg::RADIO_TX_EN;
                            tcmd  = tsch_ss_pkg::TMR_ARM;
                            tsel  = tsch_ss_pkg::TSEL_RT6;
                            phase_next = tsch_ss_pkg::PH_TXA_READY;
                        end
                    end
                    tsch_ss_pkg::PH_TXA_PREP: begin
                        err = tsch_ss_pkg::ERR_TXA_PREP; end_slot = 1'b1;
                    end
                    tsch_ss_pkg::PH_TXA_READY: begin
                        radio = tsch_ss_pkg::RADIO_TX_NOW;
                        tcmd  = tsch_ss_pkg::TMR_ARM;
                        tsel  = tsch_ss_pkg::TSEL_RT7;
                        phase_next = tsch_ss_pkg::PH_TXA_DELAY;
                    end
                    tsch_ss_pkg::PH_TXA_DELAY: begin
                        err = tsch_ss_pkg::ERR_TXA_WDOG; end_slot = 1'b1;
                    end
                    tsch_ss_pkg::PH_TXA: begin
                        err = tsch_ss_pkg::ERR_ACK_DUR; end_slot = 1'b1;
                    end
                    default: begin
                        err = tsch_ss_pkg::ERR_TIMER_PHASE; end_slot = 1'b1;
                    end
                endcase
            end
            tsch_ss_pkg::EV_START: begin
                if (!synced_reg) begin
                    capture_next = ev.captured_time;
                end else begin
                    case (phase_reg)
                        tsch_ss_pkg::PH_TXD_DELAY: begin
                            phase_next   = tsch_ss_pkg::PH_TXD;
                            capture_next = ev.captured_time;
                            tcmd = tsch_ss_pkg::TMR_CANCEL_ARM;
                            tsel = tsch_ss_pkg::TSEL_TT4;
                        end
                        tsch_ss_pkg::PH_RXA_LISTEN: begin
                            phase_next   = tsch_ss_pkg::PH_RXA;
                            capture_next = ev.captured_time;
                            tcmd = tsch_ss_pkg::TMR_CANCEL_ARM;
                            tsel = tsch_ss_pkg::TSEL_TT8;
                        end
                        tsch_ss_pkg::PH_RXD_LISTEN: begin
                            phase_next   = tsch_ss_pkg::PH_RXD;
                            capture_next = ev.captured_time;
                            tcmd = tsch_ss_pkg::TMR_CANCEL_ARM;
                            tsel = tsch_ss_pkg::TSEL_RT4;
                        end
                        tsch_ss_pkg::PH_TXA_DELAY: begin
                            phase_next   = tsch_ss_pkg::PH_TXA;
                            capture_next = ev.captured_time;
                            tcmd = tsch_ss_pkg::TMR_CANCEL_ARM;
                            tsel = tsch_ss_pkg::TSEL_RT8;
                        end
                        default: begin
                            err = tsch_ss_pkg::ERR_START_PHASE; end_slot = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                if (!synced_reg) begin
                    if (!ev.buffer_free) begin
                        err = tsch_ss_pkg::ERR_NO_BUFFER; end_slot = 1'b1;
                    end else if (ev.frame_is_beacon) begin
                        slot_next   = beacon_slot;
                        synced_next = 1'b1;
                        radio       = tsch_ss_pkg::RADIO_OFF;
                        phase_next  = tsch_ss_pkg::PH_SLEEP;
                    end
                end else begin
                    case (phase_reg)
                        tsch_ss_pkg::PH_TXD: begin
                            phase_next   = tsch_ss_pkg::PH_RXA_OFS;
                            radio        = tsch_ss_pkg::RADIO_OFF;
                            capture_next = ev.captured_time;
                            if (bcast_reg) begin
                                send         = tsch_ss_pkg::SEND_OK;
                                hold_tx_next = 1'b0;
                                end_slot     = 1'b1;
                            end else begin
                                tcmd = tsch_ss_pkg::TMR_ARM;
                                tsel = tsch_ss_pkg::TSEL_TT5;
                            end
                        end
                        tsch_ss_pkg::PH_RXA: begin
                            capture_next = ev.captured_time;
                            if (!ev.buffer_free) begin
                                err = tsch_ss_pkg::ERR_NO_BUFFER;
                            end else begin
                                send         = tsch_ss_pkg::SEND_OK;
                                hold_tx_next = 1'b0;
                            end
                            end_slot = 1'b1;
                        end
                        tsch_ss_pkg::PH_RXD: begin
                            capture_next = ev.captured_time;
                            if (!ev.buffer_free) begin
                                err = tsch_ss_pkg::ERR_NO_BUFFER; end_slot = 1'b1;
                            end else begin
                                hold_rx_next = 1'b1;
                                phase_next   = tsch_ss_pkg::PH_TXA_OFS;
                                tcmd = tsch_ss_pkg::TMR_CANCEL_ARM;
                                tsel = tsch_ss_pkg::TSEL_RT5;
                            end
                        end
                        tsch_ss_pkg::PH_TXA: begin
                            capture_next = ev.captured_time;
                            deliver      = 1'b1;
                            hold_rx_next = 1'b0;
                            end_slot     = 1'b1;
                        end
                        default: begin
                            err = tsch_ss_pkg::ERR_END_PHASE; end_slot = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        if (end_slot) begin
            radio        = tsch_ss_pkg::RADIO_OFF;
            tcmd         = tsch_ss_pkg::TMR_CANCEL;
            tsel         = tsch_ss_pkg::TSEL_NONE;
            capture_next = 16'd0;
            if (hold_tx_next) begin
                if (retries_next <= 4'd1) begin
                    retries_next = 4'd0;
                    send         = tsch_ss_pkg::SEND_FAIL;
                end else begin
                    retries_next = retries_next - 4'd1;
                end
                hold_tx_next = 1'b0;
            end
            if (hold_rx_next) begin
                deliver      = 1'b1;
                hold_rx_next = 1'b0;
            end
            phase_next = tsch_ss_pkg::PH_SLEEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= tsch_ss_pkg::PH_SLEEP;
            slot_reg    <= '0;
            synced_reg  <= 1'b0;
            capture_reg <= 16'd0;
            hold_tx_reg <= 1'b0;
            retries_reg <= 4'd0;
            bcast_reg   <= 1'b0;
            hold_rx_reg <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            slot_reg    <= slot_next;
            synced_reg  <= synced_next;
            capture_reg <= capture_next;
            hold_tx_reg <= hold_tx_next;
            retries_reg <= retries_next;
            bcast_reg   <= bcast_next;
            hold_rx_reg <= hold_rx_next;
        end else if (cfg_we) begin
            synced_reg <= cfg_wdata;
        end
    end

    always_comb begin
        res.fsm_code      = phase_next;
        res.radio_cmd     = radio;
        res.timer_cmd     = tcmd;
        res.timer_select  = tsel;
        res.send_status   = send;
        res.deliver_frame = deliver;
        res.retries_after = retries_next;
        res.error_code    = err;
        res.last_capture  = capture_next;
    end

    assign slot_out = slot_next;

endmodule

/* rtl/tsch_ss_frame_mod.sv */
// Result register and pipelined slot-number remainder, one byte per stage.
// Depends on tsch_ss_pkg.
module tsch_ss_frame_mod #(
    parameter int unsigned SLOT_BITS   = tsch_ss_pkg::SLOT_BITS_DEF,
    parameter int unsigned FRAME_SLOTS = tsch_ss_pkg::FRAME_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tsch_ss_pkg::res_t     in_res,
    input  logic [SLOT_BITS-1:0]  in_slot,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tsch_ss_pkg::res_t     m_res,
    output logic [SLOT_BITS-1:0]  m_slot,
    output logic                  m_frame_boundary
);

    localparam int unsigned NSTG = (SLOT_BITS + 7) / 8;
    localparam int unsigned PW   = NSTG * 8;
    localparam int unsigned RW   = $clog2(FRAME_SLOTS + 1);
    localparam logic [RW:0] F_W  = (RW + 1)'(FRAME_SLOTS);

    logic [NSTG:0]        v_reg;
    logic [NSTG:0]        rdy;
    tsch_ss_pkg::res_t    res_reg  [NSTG+1];
    logic [SLOT_BITS-1:0] slot_reg [NSTG+1];
    logic [RW-1:0]        rem_reg  [1:NSTG];

    function automatic logic [RW-1:0] mod_byte(input logic [RW-1:0] r, input logic [7:0] b);
        logic [RW:0]   t;
        logic [RW-1:0] acc;
        acc = r;
        for (int i = 7; i >= 0; i--) begin
            t = {acc, b[i]};
            if (t >= F_W) begin
                t = t - F_W;
            end
            acc = t[RW-1:0];
        end
        return acc;
    endfunction

    generate
        for (genvar k = 0; k < NSTG; k++) begin : gen_rdy
            assign rdy[k] = !v_reg[k] || rdy[k+1];
        end
    endgenerate
    assign rdy[NSTG] = !v_reg[NSTG] || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            res_reg[0]  <= in_res;
            slot_reg[0] <= in_slot;
        end
    end

    generate
        for (genvar k = 1; k <= NSTG; k++) begin : gen_stg
            logic [PW-1:0] pad;
            logic [RW-1:0] rem_in;
            logic [RW-1:0] rem_next;

            assign pad = PW'(slot_reg[k-1]);
            if (k == 1) begin : gen_first
                assign rem_in = '0;
            end else begin : gen_rest
                assign rem_in = rem_reg[k-1];
            end
            assign rem_next = mod_byte(rem_in, pad[(NSTG-k)*8 +: 8]);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[k]) begin
                    res_reg[k]  <= res_reg[k-1];
                    slot_reg[k] <= slot_reg[k-1];
                    rem_reg[k]  <= rem_next;
                end
            end
        end
    endgenerate

    assign in_ready         = rdy[0];
    assign m_valid          = v_reg[NSTG];
    assign m_res            = res_reg[NSTG];
    assign m_slot           = slot_reg[NSTG];
    assign m_frame_boundary = (rem_reg[NSTG] == '0);

endmodule

/* rtl/tsch_slot_sequencer_core.sv */
// Top level of the TSCH slot sequencer: input register, state machine, result pipeline.
// Depends on tsch_ss_pkg, tsch_ss_fsm and tsch_ss_frame_mod.
//
// One event beat in, one result beat out, at up to one beat per clock. An event is
// held in an input register, applied to the slot state in one combinational pass,
// and its result then passes a result register and one remainder stage per byte of
// slot number (SLOT_BITS/8 rounded up) that forms the frame-boundary flag.
// Backpressure on m_tready stalls the stages in place. A write on cfg_we sets the
// synchronized flag to cfg_wdata (node is root) unless an event is applied in the
// same cycle; write it only while no beat is in flight. No clearing pass is needed
// after reset.
module tsch_slot_sequencer_core #(
    parameter int unsigned FRAME_SLOTS = tsch_ss_pkg::FRAME_SLOTS_DEF,
    parameter int unsigned SLOT_BITS   = tsch_ss_pkg::SLOT_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic                                  cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // captured_time, cell_type, packet_ready, packet_broadcast, packet_retries,
    // buffer_free, frame_is_beacon, beacon_slot
    input  logic [((27+SLOT_BITS+7)/8)*8-1:0]     s_tdata,
    // command
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // fsm_code, radio_cmd, timer_cmd, timer_select, send_status, deliver_frame,
    // retries_after, slot_number, frame_boundary, error_code, last_capture
    output logic [((42+SLOT_BITS+7)/8)*8-1:0]     m_tdata
);

    localparam int unsigned M_DATA_W = ((42 + SLOT_BITS + 7) / 8) * 8;

    logic                 in_v_reg;
    tsch_ss_pkg::ev_t     in_ev_reg;
    logic [SLOT_BITS-1:0] in_bslot_reg;
    logic                 pipe_ready;
    logic                 fire;

    tsch_ss_pkg::res_t    fsm_res;
    logic [SLOT_BITS-1:0] fsm_slot;
    tsch_ss_pkg::res_t    out_res;
    logic [SLOT_BITS-1:0] out_slot;
    logic                 out_fb;

    assign fire     = in_v_reg && pipe_ready;
    assign s_tready = !in_v_reg || pipe_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_v_reg <= 1'b1;
        end else if (fire) begin
            in_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ev_reg.command          <= s_tuser;
            in_ev_reg.captured_time    <= s_tdata[15:0];
            in_ev_reg.cell_type        <= s_tdata[18:16];
            in_ev_reg.packet_ready     <= s_tdata[19];
            in_ev_reg.packet_broadcast <= s_tdata[20];
            in_ev_reg.packet_retries   <= s_tdata[24:21];
            in_ev_reg.buffer_free      <= s_tdata[25];
            in_ev_reg.frame_is_beacon  <= s_tdata[26];
            in_bslot_reg               <= s_tdata[27 +: SLOT_BITS];
        end
    end

    tsch_ss_fsm #(
        .SLOT_BITS (SLOT_BITS)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .step        (fire),
        .ev          (in_ev_reg),
        .beacon_slot (in_bslot_reg),
        .res         (fsm_res),
        .slot_out    (fsm_slot)
    );

    tsch_ss_frame_mod #(
        .SLOT_BITS   (SLOT_BITS),
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_frame_mod (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (in_v_reg),
        .in_ready         (pipe_ready),
        .in_res           (fsm_res),
        .in_slot          (fsm_slot),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_res            (out_res),
        .m_slot           (out_slot),
        .m_frame_boundary (out_fb)
    );

    assign m_tdata = M_DATA_W'({out_res.last_capture, out_res.error_code, out_fb, out_slot,
                                out_res.retries_after, out_res.deliver_frame,
                                out_res.send_status, out_res.timer_select,
                                out_res.timer_cmd, out_res.radio_cmd, out_res.fsm_code});

endmodule

/* rtl/tsch_ss_checker.sv */
// Port-level checker for the TSCH slot sequencer, bound to the top level.
// Depends on tsch_ss_pkg and tsch_slot_sequencer_core_defines.svh.
`include "tsch_slot_sequencer_core_defines.svh"

module tsch_ss_checker #(
    parameter int unsigned SLOT_BITS = tsch_ss_pkg::SLOT_BITS_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((42+SLOT_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned ERR_LO = 22 + SLOT_BITS;

    logic [4:0] fsm_code;
    logic [2:0] radio_cmd;
    logic [1:0] timer_cmd;
    logic [1:0] send_status;
    logic       deliver_frame;
    logic [3:0] retries_after;
    logic [3:0] error_code;

    assign fsm_code      = m_tdata[4:0];
    assign radio_cmd     = m_tdata[7:5];
    assign timer_cmd     = m_tdata[9:8];
    assign send_status   = m_tdata[15:14];
    assign deliver_frame = m_tdata[16];
    assign retries_after = m_tdata[20:17];
    assign error_code    = m_tdata[ERR_LO +: 4];

    `TSS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid,
        "result beat dropped while stalled")

    `TSS_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata),
        "result beat changed while stalled")

    `TSS_ASSERT_NOW(a_err_ends_slot,
        m_tvalid && (error_code != tsch_ss_pkg::ERR_NONE),
        (fsm_code == tsch_ss_pkg::PH_SLEEP) && (radio_cmd == tsch_ss_pkg::RADIO_OFF)
            && (timer_cmd == tsch_ss_pkg::TMR_CANCEL),
        "error did not end the slot")

    `TSS_ASSERT_NOW(a_fail_no_retries,
        m_tvalid && (send_status == tsch_ss_pkg::SEND_FAIL), retries_after == 4'd0,
        "send failure with retries left")

    `TSS_ASSERT_NOW(a_deliver_sleep, m_tvalid && deliver_frame,
        fsm_code == tsch_ss_pkg::PH_SLEEP,
        "frame delivered before slot end")

endmodule

bind tsch_slot_sequencer_core tsch_ss_checker #(
    .SLOT_BITS (SLOT_BITS)
) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
